// ===== hw/rtl/lfsw_pkg.sv =====
package lfsw_pkg;

  // Serial frame layout: one D/C bit, then eight payload bits MSB first
  localparam int unsigned FRAME_BITS = 9;
  localparam logic [3:0]  LAST_BIT   = 4'd8;
  localparam logic [1:0]  LAST_FRAME = 2'd2;   // start sends three command frames

  // Data/command line levels
  localparam logic DC_CMD  = 1'b0;
  localparam logic DC_DATA = 1'b1;

  // Command bytes: page 0, column high nibble 0, column low nibble 0
  localparam logic [7:0] CMD_PAGE0   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI0 = 8'h10;
  localparam logic [7:0] CMD_COL_LO0 = 8'h00;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Configuration register indexes
  localparam logic REG_PANEL_WIDTH  = 1'b0;
  localparam logic REG_PANEL_HEIGHT = 1'b1;

  localparam logic [7:0] PANEL_WIDTH_RST  = 8'd128;
  localparam logic [7:0] PANEL_HEIGHT_RST = 8'd64;

  localparam int unsigned COUNT_W = 13;

  // One queued job for the serialiser
  typedef struct packed {
    logic       is_start;   // three command frames, else one data frame
    logic [7:0] data_byte;  // frame buffer byte for a data job
    logic       done;       // data job closes the update
  } job_t;

  // Command byte for frame number idx of a start job
  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CMD_PAGE0;
      2'd1:    b = CMD_COL_HI0;
      default: b = CMD_COL_LO0;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/lfsw_decode.sv =====
module lfsw_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [7:0]        pixel_byte,
  input  logic              job_take,
  output logic              job_valid,
  output lfsw_pkg::job_t    job
);

  logic [7:0]                      panel_width;
  logic [7:0]                      panel_height;
  logic [lfsw_pkg::COUNT_W-1:0]    bytes_left;
  logic                            updating;

  logic                            accept;
  logic                            produces;
  logic [8:0]                      rows_sum;
  logic [5:0]                      rows;
  logic [13:0]                     product;
  logic [lfsw_pkg::COUNT_W-1:0]    count;
  logic [lfsw_pkg::COUNT_W-1:0]    bytes_left_next;
  lfsw_pkg::job_t                  job_next;

  // Handshake: the job slot frees when the serialiser takes it
  assign in_stall = job_valid && !job_take;
  assign accept   = in_valid && !in_stall;
  assign produces = (op == lfsw_pkg::OP_START) || updating;

  // Byte count: width * ceil(height / 8), fits in 13 bits
  always_comb begin
    rows_sum = {1'b0, panel_height} + 9'd7;
    rows     = rows_sum[8:3];
    product  = 14'(panel_width) * 14'(rows);
    count    = product[lfsw_pkg::COUNT_W-1:0];
  end

  assign bytes_left_next = bytes_left - 13'd1;

  // Job descriptor for the accepted item
  always_comb begin
    job_next.is_start  = (op == lfsw_pkg::OP_START);
    job_next.data_byte = pixel_byte;
    job_next.done      = (bytes_left_next == '0);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= lfsw_pkg::PANEL_WIDTH_RST;
      panel_height <= lfsw_pkg::PANEL_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        lfsw_pkg::REG_PANEL_WIDTH:  panel_width  <= cfg_data;
        lfsw_pkg::REG_PANEL_HEIGHT: panel_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Update state and job slot
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      updating   <= 1'b0;
      job_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (op == lfsw_pkg::OP_START) begin
          bytes_left <= count;
          updating   <= (count != '0);
        end else if (updating) begin
          bytes_left <= bytes_left_next;
          updating   <= (bytes_left_next != '0);
        end
      end
      if (accept && produces) begin
        job_valid <= 1'b1;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (accept && produces) begin
      job <= job_next;
    end
  end

  // An open update always has bytes outstanding
  a_updating_count: assert property (@(posedge clk) disable iff (rst)
    updating == (bytes_left != '0))
    else $error("update flag disagrees with byte count");

endmodule

// ===== hw/rtl/lfsw_serializer.sv =====
module lfsw_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  lfsw_pkg::job_t    job_in,
  output logic              job_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              serial_bit,
  output logic              frame_end,
  output logic              update_done,
  output logic              last
);

  logic            active;
  lfsw_pkg::job_t  job;
  logic [1:0]      frame_idx;
  logic [3:0]      bit_idx;
  logic [8:0]      shift;

  logic            out_load;
  logic            cur_end;
  logic            job_end;
  logic            step;
  logic [1:0]      frame_idx_next;
  logic [8:0]      first_shift;

  assign out_load       = !out_valid || !out_stall;
  assign cur_end        = (bit_idx == lfsw_pkg::LAST_BIT);
  assign job_end        = cur_end && (!job.is_start || frame_idx == lfsw_pkg::LAST_FRAME);
  assign step           = active && out_load;
  assign job_take       = job_valid && (!active || (job_end && out_load));
  assign frame_idx_next = 2'(frame_idx + 2'd1);
  assign first_shift    = job_in.is_start ? {lfsw_pkg::DC_CMD, lfsw_pkg::CMD_PAGE0}
                                          : {lfsw_pkg::DC_DATA, job_in.data_byte};

  // Sequencing: bit within frame, frame within job
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      frame_idx <= '0;
      bit_idx   <= '0;
    end else begin
      if (out_load) begin
        out_valid <= active;
      end
      if (job_take) begin
        active    <= 1'b1;
        frame_idx <= '0;
        bit_idx   <= '0;
      end else if (step) begin
        if (job_end) begin
          active  <= 1'b0;
          bit_idx <= '0;
        end else if (cur_end) begin
          frame_idx <= frame_idx_next;
          bit_idx   <= '0;
        end else begin
          bit_idx <= 4'(bit_idx + 4'd1);
        end
      end
    end
  end

  // Job and shift register payload
  always_ff @(posedge clk) begin
    if (job_take) begin
      job   <= job_in;
      shift <= first_shift;
    end else if (step) begin
      if (cur_end) begin
        shift <= {lfsw_pkg::DC_CMD, lfsw_pkg::cmd_byte(frame_idx_next)};
      end else begin
        shift <= {shift[7:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (step) begin
      serial_bit  <= shift[8];
      frame_end   <= cur_end;
      update_done <= job_end && !job.is_start && job.done;
      last        <= job_end;
    end
  end

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && update_done |-> frame_end && last)
    else $error("update_done outside the final bit of a frame");

  a_last_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> frame_end)
    else $error("last result not on a frame boundary");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    active |-> bit_idx <= lfsw_pkg::LAST_BIT)
    else $error("bit counter past end of frame");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    job_take |=> active)
    else $error("taken job not started");

endmodule

// ===== hw/rtl/lcd_frame_serial_writer.sv =====
// Serial writer for a monochrome LCD on a 3-wire, 9-bit link. Each output
// transaction is one clock pulse on the serial line: a frame is a D/C bit
// followed by a byte MSB first, nine transactions in all. A start item (op 0)
// sends the commands 0xB0, 0x10, 0x00 (27 transactions) and loads a byte count
// of panel_width * ceil(panel_height / 8); each data item (op 1) then sends one
// data frame (9 transactions) until the count is used up, update_done marking
// the final bit. Data items outside an update are taken and dropped. The rate
// is set by the bit serialiser: one bit per cycle while the receiver does not
// stall the output. One decoded item waits in a job slot while the previous one
// is shifted out, so an input transaction can be taken while the serialiser is
// busy and frames follow without gaps.
module lcd_frame_serial_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  pixel_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        serial_bit,
  output logic        frame_end,
  output logic        update_done,
  output logic        last
);

  logic            job_valid;
  logic            job_take;
  lfsw_pkg::job_t  job;

  lfsw_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .pixel_byte (pixel_byte),
    .job_take   (job_take),
    .job_valid  (job_valid),
    .job        (job)
  );

  lfsw_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_in      (job),
    .job_take    (job_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .serial_bit  (serial_bit),
    .frame_end   (frame_end),
    .update_done (update_done),
    .last        (last)
  );

endmodule

// ===== tb/lcd_frame_serial_writer_tb.sv =====
module lcd_frame_serial_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  // One serial clock pulse as seen on the output side
  typedef struct packed {
    logic serial_bit;
    logic frame_end;
    logic update_done;
    logic last;
  } pulse_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic       op;
  logic [7:0] pixel_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       serial_bit;
  logic       frame_end;
  logic       update_done;
  logic       last;

  // Shadow of the block's registers and update state
  logic [7:0]  shadow_width  = lfsw_pkg::PANEL_WIDTH_RST;
  logic [7:0]  shadow_height = lfsw_pkg::PANEL_HEIGHT_RST;
  logic [12:0] expected_left = '0;
  logic        update_open = 1'b0;

  pulse_t pending_pulses[$];
  int     mismatches = 0;
  int     productive_items = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     quiet_cycles = 0;

  lcd_frame_serial_writer i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .pixel_byte  (pixel_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .serial_bit  (serial_bit),
    .frame_end   (frame_end),
    .update_done (update_done),
    .last        (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Queue the nine pulses of one frame: D/C bit, then the byte MSB first
  function automatic void push_frame(input logic dc, input logic [7:0] b,
                                     input logic done, input logic fin);
    pulse_t p;
    int     k;
    for (k = 0; k < lfsw_pkg::FRAME_BITS; k++) begin
      p.serial_bit  = (k == 0) ? dc : b[8 - k];
      p.frame_end   = (k == lfsw_pkg::FRAME_BITS - 1);
      p.update_done = (k == lfsw_pkg::FRAME_BITS - 1) && done;
      p.last        = (k == lfsw_pkg::FRAME_BITS - 1) && fin;
      pending_pulses.push_back(p);
    end
  endfunction

  // Expected pulses for one accepted input transaction
  function automatic void predict_pulses(input logic op_v, input logic [7:0] byte_v);
    logic [8:0] rows;
    logic       done;
    if (op_v == lfsw_pkg::OP_START) begin
      push_frame(lfsw_pkg::DC_CMD, lfsw_pkg::CMD_PAGE0, 1'b0, 1'b0);
      push_frame(lfsw_pkg::DC_CMD, lfsw_pkg::CMD_COL_HI0, 1'b0, 1'b0);
      push_frame(lfsw_pkg::DC_CMD, lfsw_pkg::CMD_COL_LO0, 1'b0, 1'b1);
      rows = ({1'b0, shadow_height} + 9'd7) >> 3;
      expected_left = shadow_width * rows;
      update_open = (expected_left != '0);
      productive_items++;
    end else if (update_open) begin
      expected_left = expected_left - 13'd1;
      done = (expected_left == '0);
      push_frame(lfsw_pkg::DC_DATA, byte_v, done, 1'b1);
      if (done) update_open = 1'b0;
      productive_items++;
    end
  endfunction

  // Track register writes, predict on input, check on output
  always @(posedge clk) begin : monitor
    pulse_t got;
    pulse_t want;
    if (!rst) begin
      if (cfg_write) begin
        if (cfg_index == lfsw_pkg::REG_PANEL_WIDTH) shadow_width = cfg_data;
        else shadow_height = cfg_data;
      end
      if (in_valid && !in_stall) predict_pulses(op, pixel_byte);
      if (out_valid && !out_stall) begin
        got = '{serial_bit, frame_end, update_done, last};
        if (pending_pulses.size() == 0) begin
          $display("%0t: unexpected pulse bit=%b end=%b done=%b last=%b",
                   $time, got.serial_bit, got.frame_end, got.update_done, got.last);
          mismatches++;
        end else begin
          want = pending_pulses.pop_front();
          if (got !== want) begin
            // fields in order bit, end, done, last
            $display("%0t: pulse mismatch expected %b got %b", $time, want, got);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d pulses outstanding", $time, pending_pulses.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Present one input transaction and hold it until taken
  task automatic send_item(input logic op_v, input logic [7:0] byte_v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= op_v;
    pixel_byte <= byte_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain all expected pulses, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program both panel registers while the block is idle
  task automatic set_panel(input logic [7:0] w, input logic [7:0] h);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= lfsw_pkg::REG_PANEL_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= lfsw_pkg::REG_PANEL_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Reset geometry: data while idle, a partial update and a restart
  task automatic test_defaults();
    send_item(lfsw_pkg::OP_DATA, 8'hFF);
    send_item(lfsw_pkg::OP_START, 8'h00);
    send_item(lfsw_pkg::OP_DATA, 8'h00);
    send_item(lfsw_pkg::OP_DATA, 8'hFF);
    send_item(lfsw_pkg::OP_DATA, 8'h81);
    send_item(lfsw_pkg::OP_START, 8'hFF);
    send_item(lfsw_pkg::OP_DATA, 8'h7E);
    send_item(lfsw_pkg::OP_DATA, 8'h01);
  endtask

  // One-byte frame buffer: the first data byte closes the update
  task automatic test_single_byte();
    set_panel(8'd1, 8'd1);
    send_item(lfsw_pkg::OP_START, 8'h55);
    send_item(lfsw_pkg::OP_DATA, 8'hFF);
    send_item(lfsw_pkg::OP_DATA, 8'h00);
  endtask

  // Zero byte count from zero width or zero height
  task automatic test_zero_count();
    set_panel(8'd0, 8'd255);
    send_item(lfsw_pkg::OP_START, 8'h00);
    send_item(lfsw_pkg::OP_DATA, 8'hAA);
    set_panel(8'd5, 8'd0);
    send_item(lfsw_pkg::OP_START, 8'hFF);
    send_item(lfsw_pkg::OP_DATA, 8'h55);
  endtask

  // Largest geometry with a restart, then a small full update
  task automatic test_extremes();
    set_panel(8'd255, 8'd255);
    send_item(lfsw_pkg::OP_START, 8'h00);
    send_item(lfsw_pkg::OP_DATA, 8'h00);
    send_item(lfsw_pkg::OP_DATA, 8'hFF);
    send_item(lfsw_pkg::OP_START, 8'h00);
    send_item(lfsw_pkg::OP_DATA, 8'h80);
    set_panel(8'd2, 8'd9);
    send_item(lfsw_pkg::OP_START, 8'h00);
    send_item(lfsw_pkg::OP_DATA, 8'h00);
    send_item(lfsw_pkg::OP_DATA, 8'hFF);
    send_item(lfsw_pkg::OP_DATA, 8'hA5);
    send_item(lfsw_pkg::OP_DATA, 8'h5A);
    send_item(lfsw_pkg::OP_DATA, 8'h3C);
  endtask

  // Mostly complete updates with random content, some broken ones and noise
  task automatic test_random(input int target, input int idle_pct, input int stall_p);
    int goal;
    int w;
    int h;
    int count;
    int n;
    int kind;
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    goal = productive_items + target;
    w = 4;
    h = 8;
    while (productive_items < goal) begin
      if ($urandom_range(1) == 0) begin
        if ($urandom_range(99) < 10) begin
          case ($urandom_range(2))
            0: w = 0;
            1: w = 1;
            default: w = 255;
          endcase
          case ($urandom_range(3))
            0: h = 0;
            1: h = 1;
            2: h = 9;
            default: h = 255;
          endcase
        end else begin
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 24);
        end
        set_panel(w[7:0], h[7:0]);
      end
      count = w * ((h + 7) / 8);
      n = (count > 24) ? 24 : count;
      kind = $urandom_range(99);
      if (kind < 70) begin
        repeat ($urandom_range(1)) send_item(lfsw_pkg::OP_DATA, 8'($urandom_range(255)));
        send_item(lfsw_pkg::OP_START, 8'($urandom_range(255)));
        repeat (n) send_item(lfsw_pkg::OP_DATA, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0) send_item(lfsw_pkg::OP_DATA, 8'($urandom_range(255)));
      end else if (kind < 85) begin
        // update cut short by a fresh start
        send_item(lfsw_pkg::OP_START, 8'($urandom_range(255)));
        repeat ($urandom_range(n)) send_item(lfsw_pkg::OP_DATA, 8'($urandom_range(255)));
        send_item(lfsw_pkg::OP_START, 8'($urandom_range(255)));
        repeat (n) send_item(lfsw_pkg::OP_DATA, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = lfsw_pkg::REG_PANEL_WIDTH;
    cfg_data   = '0;
    in_valid   = 1'b0;
    op         = lfsw_pkg::OP_START;
    pixel_byte = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_single_byte();
    test_zero_count();
    test_extremes();
    test_random(80, 0, 0);
    test_random(80, 80, 0);
    test_random(80, 0, 80);
    test_random(80, 20, 20);
    wait_idle();

    if (mismatches == 0 && pending_pulses.size() == 0) begin
      $display("tb: success");
    end else begin
      if (pending_pulses.size() != 0)
        $display("%0t: %0d expected pulses never arrived", $time, pending_pulses.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
